// ===== hdl/gpss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the grid pressure SOR solver.
// Used by grid_pressure_sor_solver_top; depends on nothing else.
package gpss_pkg;

    localparam int DEF_MAX_DIM   = 16;
    localparam int DEF_MAX_CELLS = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int RES_W      = 41;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd5;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_SOLVE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_CELL,
        ST_FLAG,
        ST_NBR,
        ST_NLAST,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_UPD,
        ST_ADV,
        ST_SWEEP,
        ST_DONE
    } fsm_state_t;

endpackage

// ===== hdl/grid_pressure_sor_solver_top.sv =====
`timescale 1ns / 1ps
// Grid pressure SOR solver: cell memories, sweep sequencer and result queue.
// Depends on gpss_pkg.
//
// The input stream carries load, solve and read requests; every request
// yields exactly one result beat on the output stream. A load writes the
// fluid flag and divergence of one cell in its accept cycle; a read's
// pressure is registered from the memory, then put in the result queue.
// Both stream at one beat per cycle while the queue has room. A solve runs
// Gauss-Seidel sweeps over the grid in use: per fluid cell one pressure
// read per neighbor, then a 49-step shift-subtract divide by the neighbor
// count; empty cells are written with zero, cells beyond the memory are
// skipped. Its result is queued when the solve ends. After reset the block
// zeroes the pressure memory word by word and takes no request until done;
// configuration writes are taken at any time.
// Results sit in a two-beat queue: while the receiver stalls, requests keep
// being taken until the queue has no room left for their result.
module grid_pressure_sor_solver_top #(
    parameter int MAX_DIM   = gpss_pkg::DEF_MAX_DIM,
    parameter int MAX_CELLS = gpss_pkg::DEF_MAX_CELLS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [gpss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gpss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_index[11:0], is_fluid[12], divergence[44:13], zero fill
    input  logic [gpss_pkg::IN_DATA_W-1:0]      s_tdata,
    // req_type[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pressure_out[31:0], sweeps_done[39:32], converged[40], zero fill
    output logic [gpss_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import gpss_pkg::*;

    localparam int AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int LW   = 3 * DW;
    localparam int SUMW = 35;
    localparam int PW   = SUMW + 14;
    localparam int TW   = PW + 1;
    localparam int CW   = $clog2(PW);

    fsm_state_t state_reg, state_next;

    logic [4:0]  grid_x_reg, grid_y_reg, grid_z_reg;
    logic [12:0] relax_reg;
    logic [7:0]  max_sweeps_reg;
    logic [30:0] tol_reg;

    logic [31:0] p_mem [MAX_CELLS];
    logic [32:0] fd_mem [MAX_CELLS];
    logic [31:0] p_q_reg;
    logic [32:0] fd_q_reg;
    logic          p_we, fd_we;
    logic [AW-1:0] p_waddr, p_raddr, fd_waddr, fd_raddr;
    logic [31:0]   p_wdata;
    logic [32:0]   fd_wdata;

    logic [AW-1:0]   clr_reg, clr_next;
    logic [DW-1:0]   nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic [2*DW-1:0] plane_reg, plane_next;
    logic [DW-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [LW-1:0]   idx_reg, idx_next, base_reg, base_next;
    logic [7:0]      sweep_reg, sweep_next;
    logic            conv_reg, conv_next;
    logic [32:0]     largest_reg, largest_next;
    logic [31:0]     old_reg, old_next;
    logic [2:0]      dir_reg, dir_next, cnt_reg, cnt_next;
    logic            npend_reg, npend_next, nin_reg, nin_next;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [45:0]     bterm_reg, bterm_next;
    logic            neg_reg, neg_next;
    logic [PW-1:0]   dmag_reg, dmag_next, quo_reg, quo_next;
    logic [2:0]      rem_reg, rem_next;
    logic [CW-1:0]   dcnt_reg, dcnt_next;
    logic            rpend_reg, rpend_next, rrd_reg, rrd_next;

    logic [RES_W-1:0] fifo_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       fcnt_reg;
    logic             push, pop, room, accept;
    logic [RES_W-1:0] push_data;

    logic [DW-1:0]    nx_c, ny_c, nz_c;
    logic [AW-1:0]    s_addr;
    logic             s_in_range, idx_in_range;
    logic [LW-1:0]    nbr_addr;
    logic             nbr_valid, nbr_in;
    logic signed [SUMW-1:0] nbr_val, sum_acc;
    logic [3:0]       dstep;
    logic signed [PW-1:0] a_val;
    logic signed [TW-1:0] tot, tot_adj, qv;
    logic signed [31:0]   nv;
    logic signed [32:0]   dv;
    logic [32:0]          dmag_abs;

    function automatic logic [DW-1:0] clamp_dim(input logic [4:0] v);
        if (v == 5'd0) begin
            return DW'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end
        return DW'(v);
    endfunction

    assign nx_c = clamp_dim(grid_x_reg);
    assign ny_c = clamp_dim(grid_y_reg);
    assign nz_c = clamp_dim(grid_z_reg);

    assign s_addr       = AW'(s_tdata[11:0]);
    assign s_in_range   = 32'(s_tdata[11:0]) < MAX_CELLS;
    assign idx_in_range = 32'(idx_reg) < MAX_CELLS;

    always_comb begin
        nbr_valid = 1'b0;
        nbr_addr  = idx_reg;
        case (dir_reg)
            3'd0: begin
                nbr_valid = i_reg != '0;
                nbr_addr  = idx_reg - LW'(1);
            end
            3'd1: begin
                nbr_valid = (i_reg + DW'(1)) < nx_reg;
                nbr_addr  = idx_reg + LW'(1);
            end
            3'd2: begin
                nbr_valid = j_reg != '0;
                nbr_addr  = idx_reg - LW'(nx_reg);
            end
            3'd3: begin
                nbr_valid = (j_reg + DW'(1)) < ny_reg;
                nbr_addr  = idx_reg + LW'(nx_reg);
            end
            3'd4: begin
                nbr_valid = k_reg != '0;
                nbr_addr  = idx_reg - LW'(plane_reg);
            end
            3'd5: begin
                nbr_valid = (k_reg + DW'(1)) < nz_reg;
                nbr_addr  = idx_reg + LW'(plane_reg);
            end
            default: begin
                nbr_valid = 1'b0;
                nbr_addr  = idx_reg;
            end
        endcase
    end

    assign nbr_in  = 32'(nbr_addr) < MAX_CELLS;
    assign nbr_val = nin_reg ? SUMW'($signed(p_q_reg)) : '0;
    assign sum_acc = npend_reg ? sum_reg + nbr_val : sum_reg;
    assign dstep   = {rem_reg, dmag_reg[PW-1]};

    assign a_val    = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign tot      = TW'(a_val) + TW'(bterm_reg);
    assign tot_adj  = tot[TW-1] ? tot + TW'(4095) : tot;
    assign qv       = tot_adj >>> 12;
    assign nv       = (qv > TW'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                      (qv < -TW'(33'sh0_8000_0000)) ? 32'sh8000_0000 : qv[31:0];
    assign dv       = 33'(nv) - 33'($signed(old_reg));
    assign dmag_abs = dv[32] ? 33'(-dv) : 33'(dv);

    assign room   = ({1'b0, fcnt_reg} + {2'b0, rpend_reg}) < (3'd2 + {2'b0, pop});
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && room;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        nz_next      = nz_reg;
        plane_next   = plane_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        sweep_next   = sweep_reg;
        conv_next    = conv_reg;
        largest_next = largest_reg;
        old_next     = old_reg;
        dir_next     = dir_reg;
        cnt_next     = cnt_reg;
        npend_next   = 1'b0;
        nin_next     = nin_reg;
        sum_next     = sum_reg;
        prod_next    = prod_reg;
        bterm_next   = bterm_reg;
        neg_next     = neg_reg;
        dmag_next    = dmag_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        rpend_next   = 1'b0;
        rrd_next     = rrd_reg;
        p_we         = 1'b0;
        p_waddr      = AW'(idx_reg);
        p_wdata      = '0;
        p_raddr      = AW'(idx_reg);
        fd_we        = 1'b0;
        fd_waddr     = s_addr;
        fd_wdata     = {s_tdata[12], s_tdata[44:13]};
        fd_raddr     = AW'(idx_reg);
        case (state_reg)
            ST_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == MAX_CELLS - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                p_raddr = s_addr;
                if (accept) begin
                    case (s_tuser)
                        REQ_LOAD: begin
                            fd_we      = s_in_range;
                            rpend_next = 1'b1;
                            rrd_next   = 1'b0;
                        end
                        REQ_READ: begin
                            rpend_next = 1'b1;
                            rrd_next   = s_in_range;
                        end
                        REQ_SOLVE: begin
                            state_next = ST_START;
                        end
                        default: begin
                            rpend_next = 1'b1;
                            rrd_next   = 1'b0;
                        end
                    endcase
                end
            end
            ST_START: begin
                nx_next      = nx_c;
                ny_next      = ny_c;
                nz_next      = nz_c;
                plane_next   = (2*DW)'(nx_c) * (2*DW)'(ny_c);
                sweep_next   = '0;
                conv_next    = 1'b0;
                largest_next = '0;
                i_next       = '0;
                j_next       = '0;
                k_next       = '0;
                idx_next     = '0;
                base_next    = '0;
                state_next   = (max_sweeps_reg == 8'd0) ? ST_DONE : ST_CELL;
            end
            ST_CELL: begin
                state_next = idx_in_range ? ST_FLAG : ST_ADV;
            end
            ST_FLAG: begin
                old_next = p_q_reg;
                if (!fd_q_reg[32]) begin
                    p_we       = 1'b1;
                    state_next = ST_ADV;
                end else begin
                    sum_next   = -SUMW'($signed(fd_q_reg[31:0]));
                    cnt_next   = '0;
                    dir_next   = '0;
                    state_next = ST_NBR;
                end
            end
            ST_NBR: begin
                sum_next = sum_acc;
                p_raddr  = AW'(nbr_addr);
                if (nbr_valid) begin
                    cnt_next   = cnt_reg + 3'd1;
                    npend_next = 1'b1;
                    nin_next   = nbr_in;
                end
                dir_next = dir_reg + 3'd1;
                if (dir_reg == 3'd5) begin
                    state_next = ST_NLAST;
                end
            end
            ST_NLAST: begin
                sum_next = sum_acc;
                if (cnt_reg == 3'd0) begin
                    p_we       = 1'b1;
                    state_next = ST_ADV;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PW'(sum_reg) * PW'($signed({1'b0, relax_reg}));
                bterm_next = 46'($signed(old_reg))
                           * 46'($signed(14'd4096 - {1'b0, relax_reg}));
                state_next = ST_PREP;
            end
            ST_PREP: begin
                neg_next   = prod_reg[PW-1];
                dmag_next  = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
                quo_next   = '0;
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                dmag_next = dmag_reg << 1;
                if (dstep >= {1'b0, cnt_reg}) begin
                    rem_next = 3'(dstep - {1'b0, cnt_reg});
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end else begin
                    rem_next = dstep[2:0];
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + CW'(1);
                if (32'(dcnt_reg) == PW - 1) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                p_we    = 1'b1;
                p_wdata = nv;
                if (dmag_abs > largest_reg) begin
                    largest_next = dmag_abs;
                end
                state_next = ST_ADV;
            end
            ST_ADV: begin
                state_next = ST_CELL;
                if ((k_reg + DW'(1)) < nz_reg) begin
                    k_next   = k_reg + DW'(1);
                    idx_next = idx_reg + LW'(plane_reg);
                end else if ((j_reg + DW'(1)) < ny_reg) begin
                    k_next    = '0;
                    j_next    = j_reg + DW'(1);
                    base_next = base_reg + LW'(nx_reg);
                    idx_next  = base_reg + LW'(nx_reg);
                end else if ((i_reg + DW'(1)) < nx_reg) begin
                    k_next    = '0;
                    j_next    = '0;
                    i_next    = i_reg + DW'(1);
                    base_next = LW'(i_reg) + LW'(1);
                    idx_next  = LW'(i_reg) + LW'(1);
                end else begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                sweep_next   = sweep_reg + 8'd1;
                largest_next = '0;
                i_next       = '0;
                j_next       = '0;
                k_next       = '0;
                idx_next     = '0;
                base_next    = '0;
                if (largest_reg < {2'b0, tol_reg}) begin
                    conv_next  = 1'b1;
                    state_next = ST_DONE;
                end else if ((sweep_reg + 8'd1) == max_sweeps_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CELL;
                end
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            p_mem[p_waddr] <= p_wdata;
        end
        p_q_reg <= p_mem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fd_we) begin
            fd_mem[fd_waddr] <= fd_wdata;
        end
        fd_q_reg <= fd_mem[fd_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_x_reg     <= 5'd16;
            grid_y_reg     <= 5'd16;
            grid_z_reg     <= 5'd16;
            relax_reg      <= 13'd6554;
            max_sweeps_reg <= 8'd50;
            tol_reg        <= 31'd655;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GRID_X:     grid_x_reg     <= cfg_wdata[4:0];
                CFG_GRID_Y:     grid_y_reg     <= cfg_wdata[4:0];
                CFG_GRID_Z:     grid_z_reg     <= cfg_wdata[4:0];
                CFG_RELAX:      relax_reg      <= cfg_wdata[12:0];
                CFG_MAX_SWEEPS: max_sweeps_reg <= cfg_wdata[7:0];
                CFG_TOLERANCE:  tol_reg        <= cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            npend_reg <= 1'b0;
            rpend_reg <= 1'b0;
        end else begin
            clr_reg   <= clr_next;
            npend_reg <= npend_next;
            rpend_reg <= rpend_next;
        end
    end

    always_ff @(posedge aclk) begin
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        nz_reg      <= nz_next;
        plane_reg   <= plane_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        base_reg    <= base_next;
        sweep_reg   <= sweep_next;
        conv_reg    <= conv_next;
        largest_reg <= largest_next;
        old_reg     <= old_next;
        dir_reg     <= dir_next;
        cnt_reg     <= cnt_next;
        nin_reg     <= nin_next;
        sum_reg     <= sum_next;
        prod_reg    <= prod_next;
        bterm_reg   <= bterm_next;
        neg_reg     <= neg_next;
        dmag_reg    <= dmag_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        rrd_reg     <= rrd_next;
    end

    assign push      = rpend_reg || (state_reg == ST_DONE);
    assign pop       = m_tvalid && m_tready;
    assign push_data = rpend_reg ? {9'd0, (rrd_reg ? p_q_reg : 32'd0)}
                                 : {conv_reg, sweep_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fcnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            fcnt_reg <= fcnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign m_tvalid = fcnt_reg != 2'd0;
    assign m_tdata  = {(OUT_DATA_W - RES_W)'(0), fifo_reg[rp_reg]};

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (fcnt_reg != 2'd2))
        else $error("result queue overflow");

    a_div_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> ($past(state_reg) == ST_DIV
                                   && 32'($past(dcnt_reg)) == PW - 1))
        else $error("update entered before the divide finished");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (cnt_reg != 3'd0 && cnt_reg <= 3'd6))
        else $error("neighbor count out of range");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (sweep_reg <= max_sweeps_reg))
        else $error("solve ran more sweeps than allowed");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_pressure_sor_solver_top: loads, solves and reads
// are predicted by an in-bench SOR model and each result beat is compared field by field.
// Depends on gpss_pkg and the solver RTL.
module testbench;
    import gpss_pkg::*;

    localparam int NCELLS = DEF_MAX_CELLS;
    localparam int NDIM = DEF_MAX_DIM;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic               converged;
        logic [7:0]         sweeps;
        logic signed [31:0] pressure;
    } solver_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    grid_pressure_sor_solver_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Solver state as the bench sees it.
    logic [4:0]  grid_x_reg, grid_y_reg, grid_z_reg;
    logic [12:0] relax_reg;
    logic [7:0]  sweep_limit_reg;
    logic [30:0] tolerance_reg;
    logic signed [31:0] cell_pressure [NCELLS];
    logic signed [31:0] cell_divergence [NCELLS];
    bit cell_fluid [NCELLS];

    solver_result_t pending_results[$];
    int mismatches = 0;
    int loads_sent = 0, solves_sent = 0, reads_sent = 0, others_sent = 0;
    int converged_seen = 0, results_seen = 0;
    int send_idle_mode = 1;   // 0: never idle, 1: random gaps
    int recv_idle_mode = 1;
    int recv_hold = 0;
    longint cycle_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int eff_dim(logic [4:0] v);
        if (v == 0) return 1;
        if (v > NDIM) return NDIM;
        return int'(v);
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One Gauss-Seidel sweep over the grid in use; returns the largest change.
    function automatic longint relax_sweep();
        int nx, ny, nz, plane, idx, i, j, k;
        longint sum, cnt, old, a, b, nv, d, largest, w;
        nx = eff_dim(grid_x_reg);
        ny = eff_dim(grid_y_reg);
        nz = eff_dim(grid_z_reg);
        plane = nx * ny;
        w = longint'(relax_reg);
        largest = 0;
        for (i = 0; i < nx; i++)
            for (j = 0; j < ny; j++)
                for (k = 0; k < nz; k++) begin
                    idx = k * plane + j * nx + i;
                    if (!cell_fluid[idx]) begin
                        cell_pressure[idx] = 0;
                        continue;
                    end
                    sum = 0;
                    cnt = 0;
                    if (i > 0)      begin cnt++; sum += cell_pressure[idx - 1]; end
                    if (i + 1 < nx) begin cnt++; sum += cell_pressure[idx + 1]; end
                    if (j > 0)      begin cnt++; sum += cell_pressure[idx - nx]; end
                    if (j + 1 < ny) begin cnt++; sum += cell_pressure[idx + nx]; end
                    if (k > 0)      begin cnt++; sum += cell_pressure[idx - plane]; end
                    if (k + 1 < nz) begin cnt++; sum += cell_pressure[idx + plane]; end
                    if (cnt == 0) begin
                        cell_pressure[idx] = 0;
                        continue;
                    end
                    sum -= longint'(cell_divergence[idx]);
                    old = longint'(cell_pressure[idx]);
                    a = (sum * w) / cnt;
                    b = (4096 - w) * old;
                    nv = (a + b) / 4096;
                    if (nv > 64'sd2147483647) nv = 64'sd2147483647;
                    if (nv < -64'sd2147483648) nv = -64'sd2147483648;
                    cell_pressure[idx] = nv[31:0];
                    d = nv - old;
                    if (d < 0) d = -d;
                    if (d > largest) largest = d;
                end
        return largest;
    endfunction

    function automatic solver_result_t apply_request(req_t req, logic [11:0] idx,
                                                     logic fluid, logic signed [31:0] dv);
        solver_result_t r;
        int s;
        r = '0;
        case (req)
            REQ_LOAD: begin
                cell_fluid[idx] = fluid;
                cell_divergence[idx] = dv;
            end
            REQ_SOLVE: begin
                for (s = 0; s < int'(sweep_limit_reg); s++) begin
                    r.sweeps = r.sweeps + 8'd1;
                    if (relax_sweep() < longint'(tolerance_reg)) begin
                        r.converged = 1'b1;
                        break;
                    end
                end
            end
            REQ_READ: r.pressure = cell_pressure[idx];
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(req_t req, logic [11:0] idx, logic fluid,
                                logic signed [31:0] dv);
        int gap;
        gap = (send_idle_mode != 0) ? random_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = req;
        s_tdata = {3'b000, dv, fluid, idx};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_request(req, idx, fluid, dv));
        case (req)
            REQ_LOAD: loads_sent++;
            REQ_SOLVE: solves_sent++;
            REQ_READ: reads_sent++;
            default: others_sent++;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [30:0] value);
        wait_drained();
        cfg_we = 1'b1;
        cfg_index = sel;
        cfg_wdata = value;
        case (sel)
            CFG_GRID_X: grid_x_reg = value[4:0];
            CFG_GRID_Y: grid_y_reg = value[4:0];
            CFG_GRID_Z: grid_z_reg = value[4:0];
            CFG_RELAX: relax_reg = value[12:0];
            CFG_MAX_SWEEPS: sweep_limit_reg = value[7:0];
            CFG_TOLERANCE: tolerance_reg = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_grid(logic [4:0] gx, logic [4:0] gy, logic [4:0] gz);
        write_reg(CFG_GRID_X, 31'(gx));
        write_reg(CFG_GRID_Y, 31'(gy));
        write_reg(CFG_GRID_Z, 31'(gz));
    endtask

    function automatic logic signed [31:0] random_divergence();
        if ($urandom_range(0, 9) < 2) return $urandom;
        return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endfunction

    // Every cell of the grid in use gets a flag and divergence before a solve.
    task automatic load_grid(int fluid_pct);
        int n, c;
        n = eff_dim(grid_x_reg) * eff_dim(grid_y_reg) * eff_dim(grid_z_reg);
        for (c = 0; c < n; c++)
            send_request(REQ_LOAD, c[11:0], $urandom_range(0, 99) < fluid_pct,
                         random_divergence());
    endtask

    // Result checker.
    always @(posedge aclk) begin
        solver_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[40:0];
            results_seen++;
            if (got.converged) converged_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[47:41] !== 7'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pressure %0d/%0d sweeps %0d/%0d conv %0b/%0b",
                                 want.pressure, got.pressure, want.sweeps, got.sweeps,
                                 want.converged, got.converged);
                end
            end
        end
    end

    // Result receiver with random backpressure and commanded long hold-offs.
    initial begin
        forever begin
            @(negedge aclk);
            if (recv_hold > 0) begin
                m_tready = 1'b0;
                recv_hold--;
            end else if (recv_idle_mode == 0) begin
                m_tready = 1'b1;
            end else begin
                m_tready = (random_gap() == 0);
            end
        end
    end

    task automatic test_after_reset();
        send_request(REQ_READ, 12'd0, 1'b0, 32'sd0);
        send_request(REQ_READ, 12'hFFF, 1'b1, -32'sd1);
        send_request(REQ_NONE, 12'hABC, 1'b1, 32'h5A5A_A5A5);
        send_request(REQ_NONE, 12'h543, 1'b0, 32'h0);
    endtask

    task automatic test_extremes();
        int c;
        set_grid(5'd31, 5'd0, 5'd1);
        write_reg(CFG_RELAX, 31'd8191);
        write_reg(CFG_MAX_SWEEPS, 31'd255);
        write_reg(CFG_TOLERANCE, 31'd0);
        for (c = 0; c < NDIM; c++)
            send_request(REQ_LOAD, c[11:0], c != 5,
                         c[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000);
        send_request(REQ_SOLVE, 12'd0, 1'b0, 32'sd0);
        send_request(REQ_READ, 12'd0, 1'b0, 32'sd0);
        send_request(REQ_READ, 12'd5, 1'b0, 32'sd0);
        send_request(REQ_READ, 12'd15, 1'b0, 32'sd0);
        write_reg(CFG_TOLERANCE, 31'h7FFF_FFFF);
        set_grid(5'd1, 5'd1, 5'd31);
        for (c = 0; c < NDIM; c++)
            send_request(REQ_LOAD, c[11:0], 1'b1, random_divergence());
        send_request(REQ_SOLVE, 12'd0, 1'b0, 32'sd0);
        send_request(REQ_READ, 12'd7, 1'b0, 32'sd0);
    endtask

    task automatic test_lone_cell();
        set_grid(5'd1, 5'd1, 5'd1);
        write_reg(CFG_RELAX, 31'd4096);
        write_reg(CFG_MAX_SWEEPS, 31'd3);
        send_request(REQ_LOAD, 12'd0, 1'b1, 32'sd65536);
        send_request(REQ_SOLVE, 12'd0, 1'b0, 32'sd0);
        write_reg(CFG_TOLERANCE, 31'd0);
        send_request(REQ_SOLVE, 12'd0, 1'b0, 32'sd0);
        write_reg(CFG_MAX_SWEEPS, 31'd0);
        send_request(REQ_SOLVE, 12'd0, 1'b0, 32'sd0);
        send_request(REQ_READ, 12'd0, 1'b0, 32'sd0);
    endtask

    task automatic test_wide_plane();
        int c;
        set_grid(5'd16, 5'd16, 5'd1);
        write_reg(CFG_RELAX, 31'd0);
        write_reg(CFG_MAX_SWEEPS, 31'd1);
        write_reg(CFG_TOLERANCE, 31'd655);
        load_grid(80);
        send_request(REQ_SOLVE, 12'd0, 1'b0, 32'sd0);
        write_reg(CFG_RELAX, 31'd6554);
        write_reg(CFG_MAX_SWEEPS, 31'd2);
        send_request(REQ_SOLVE, 12'd0, 1'b0, 32'sd0);
        for (c = 0; c < 8; c++)
            send_request(REQ_READ, 12'($urandom_range(0, 255)), 1'b0, 32'sd0);
    endtask

    task automatic test_backpressure();
        int c;
        recv_hold = 300;
        send_idle_mode = 0;
        for (c = 0; c < 30; c++)
            send_request(c[0] ? REQ_READ : REQ_LOAD, 12'($urandom), 1'($urandom),
                         random_divergence());
        send_idle_mode = 1;
        wait_drained();
        recv_idle_mode = 0;
        for (c = 0; c < 30; c++)
            send_request(REQ_READ, 12'($urandom), 1'b0, 32'sd0);
        recv_idle_mode = 1;
    endtask

    task automatic test_random_phases();
        int phase, n, r, cells;
        logic [11:0] idx;
        for (phase = 0; phase < 14; phase++) begin
            set_grid(5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)),
                     5'($urandom_range(0, 3)));
            write_reg(CFG_RELAX, ($urandom_range(0, 3) == 0) ? 31'(13'($urandom))
                                                             : 31'($urandom_range(3000, 7500)));
            write_reg(CFG_MAX_SWEEPS, 31'($urandom_range(1, 4)));
            write_reg(CFG_TOLERANCE, ($urandom_range(0, 4) == 0) ? 31'($urandom)
                                                                 : 31'($urandom_range(0, 40000)));
            send_idle_mode = (phase % 4 == 3) ? 0 : 1;
            recv_idle_mode = (phase % 5 == 2) ? 0 : 1;
            load_grid($urandom_range(50, 100));
            cells = eff_dim(grid_x_reg) * eff_dim(grid_y_reg) * eff_dim(grid_z_reg);
            for (n = 0; n < 90; n++) begin
                r = $urandom_range(0, 99);
                idx = ($urandom_range(0, 2) == 0) ? 12'($urandom)
                                                  : 12'($urandom_range(0, cells - 1));
                if (r < 45)
                    send_request(REQ_LOAD, idx, 1'($urandom), random_divergence());
                else if (r < 85)
                    send_request(REQ_READ, idx, 1'($urandom), 32'($urandom));
                else if (r < 93)
                    send_request(REQ_SOLVE, 12'($urandom), 1'($urandom), 32'($urandom));
                else
                    send_request(REQ_NONE, 12'($urandom), 1'($urandom), 32'($urandom));
            end
        end
        send_idle_mode = 1;
        recv_idle_mode = 1;
    endtask

    initial begin
        int c;
        grid_x_reg = 5'd16; grid_y_reg = 5'd16; grid_z_reg = 5'd16;
        relax_reg = 13'd6554; sweep_limit_reg = 8'd50; tolerance_reg = 31'd655;
        for (c = 0; c < NCELLS; c++) begin
            cell_pressure[c] = 0;
            cell_divergence[c] = 0;
            cell_fluid[c] = 0;
        end
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        test_after_reset();
        test_extremes();
        test_lone_cell();
        test_wide_plane();
        test_backpressure();
        test_random_phases();
        wait_drained();
        repeat (20) @(negedge aclk);
        $display("covered %0d loads, %0d solves, %0d reads, %0d unknown requests",
                 loads_sent, solves_sent, reads_sent, others_sent);
        $display("%0d result beats checked, %0d converged solves, %0d mismatches",
                 results_seen, converged_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

// ===== grid_pressure_sor_solver_top.f =====
hdl/gpss_pkg.sv
hdl/grid_pressure_sor_solver_top.sv
dv/testbench.sv
